@@ design/bde_pkg.sv @@
// ----------------------------------------------------------------------------
// bde_pkg
// Shared types and constants for the debounced push-button event unit.
// ----------------------------------------------------------------------------
`default_nettype none

package bde_pkg;

    localparam int unsigned TIME_W       = 32;
    localparam int unsigned SAMPLE_W     = 10;
    localparam int unsigned DEBOUNCE_W   = 8;
    localparam int unsigned COUNT_W      = 4;
    localparam int unsigned REARM_W      = 16;
    localparam int unsigned KIND_W       = 2;
    localparam int unsigned CFG_INDEX_W  = 3;
    localparam int unsigned CFG_DATA_W   = 16;

    // event codes
    localparam logic [KIND_W-1:0] EV_PRESS   = 2'd0;
    localparam logic [KIND_W-1:0] EV_HOLD    = 2'd1;
    localparam logic [KIND_W-1:0] EV_RELEASE = 2'd2;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_SAMPLE_PERIOD   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEBOUNCE_PERIOD = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEBOUNCE_COUNT  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_REARM_DELAY     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_ACTIVE_LEVEL    = 3'd4;

    // reset values of the configuration registers
    localparam logic [SAMPLE_W-1:0]   RST_SAMPLE_PERIOD   = 10'd20;
    localparam logic [DEBOUNCE_W-1:0] RST_DEBOUNCE_PERIOD = 8'd5;
    localparam logic [COUNT_W-1:0]    RST_DEBOUNCE_COUNT  = 4'd3;
    localparam logic [REARM_W-1:0]    RST_REARM_DELAY     = 16'd50;
    localparam logic                  RST_ACTIVE_LEVEL    = 1'b0;

    typedef struct packed {
        logic [TIME_W-1:0] now_ms;
        logic              pin_level;
        logic              suppress_release;
    } in_item_t;

    typedef struct packed {
        logic [KIND_W-1:0] event_kind;
        logic [TIME_W-1:0] elapsed_ms;
    } out_item_t;

endpackage

`default_nettype wire

@@ design/button_debounce_events_unit.sv @@
// ----------------------------------------------------------------------------
// button_debounce_events_unit
// Turns timed raw pin polls into debounced press, hold and release events.
// ----------------------------------------------------------------------------
// One poll is taken every clock cycle while input stall is low. A poll is
// registered on entry, then the sampling, settling and event decision is
// made in combinational logic on the held state, and any event lands in a
// result register. The state update of one poll is complete before the
// next poll is evaluated, so consecutive polls need no gap. Input stall
// is raised only while a poll waits behind an event that is itself stalled.
// Configuration registers are to be written while no poll is in flight.
`default_nettype none

module button_debounce_events_unit
(
    input  wire                                    clk,
    input  wire                                    rst_n,

    input  wire                                    in_valid,
    output logic                                   in_stall,
    input  bde_pkg::in_item_t                      in_data,

    output logic                                   out_valid,
    input  wire                                    out_stall,
    output bde_pkg::out_item_t                     out_data,

    input  wire                                    cfg_we,
    input  wire  [bde_pkg::CFG_INDEX_W-1:0]        cfg_index,
    input  wire  [bde_pkg::CFG_DATA_W-1:0]         cfg_data
);

    // configuration
    logic [bde_pkg::SAMPLE_W-1:0]   sample_period_reg;
    logic [bde_pkg::DEBOUNCE_W-1:0] debounce_period_reg;
    logic [bde_pkg::COUNT_W-1:0]    debounce_count_reg;
    logic [bde_pkg::REARM_W-1:0]    rearm_delay_reg;
    logic                           active_level_reg;

    // input stage
    logic                           in_valid_reg;
    bde_pkg::in_item_t              in_data_reg;

    // debounce state
    logic [bde_pkg::TIME_W-1:0]     last_sample_time_reg, last_sample_time_next;
    logic [bde_pkg::COUNT_W-1:0]    settle_count_reg, settle_count_next;
    logic                           last_level_reg, last_level_next;
    logic                           pressed_reg, pressed_next;
    logic [bde_pkg::TIME_W-1:0]     press_time_reg, press_time_next;
    logic [bde_pkg::TIME_W-1:0]     release_time_reg, release_time_next;
    logic                           release_muted_reg, release_muted_next;

    // result stage
    logic                           out_valid_reg;
    bde_pkg::out_item_t             out_data_reg;

    logic                           advance;
    logic [bde_pkg::TIME_W-1:0]     since_sample;
    logic [bde_pkg::TIME_W-1:0]     since_release;
    logic [bde_pkg::TIME_W-1:0]     since_press;
    logic [bde_pkg::TIME_W-1:0]     spacing;
    logic                           sampled;
    logic [bde_pkg::COUNT_W-1:0]    settle_eff;
    logic                           commit;
    logic                           now_pressed;
    logic                           rearm_ok;
    logic                           emit;
    bde_pkg::out_item_t             result;

    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        since_sample  = in_data_reg.now_ms - last_sample_time_reg;
        since_release = in_data_reg.now_ms - release_time_reg;
        since_press   = in_data_reg.now_ms - press_time_reg;
        if (settle_count_reg == '0)
        begin
            spacing = {{(bde_pkg::TIME_W-bde_pkg::SAMPLE_W){1'b0}}, sample_period_reg};
        end
        else
        begin
            spacing = {{(bde_pkg::TIME_W-bde_pkg::DEBOUNCE_W){1'b0}}, debounce_period_reg};
        end
        sampled    = since_sample >= spacing;
        // a level change restarts settling
        settle_eff = (in_data_reg.pin_level != last_level_reg) ? bde_pkg::COUNT_W'(1)
                                                               : settle_count_reg;
        commit      = settle_eff >= debounce_count_reg;
        now_pressed = in_data_reg.pin_level == active_level_reg;
        rearm_ok    = since_release >= {{(bde_pkg::TIME_W-bde_pkg::REARM_W){1'b0}},
                                        rearm_delay_reg};

        last_sample_time_next = last_sample_time_reg;
        settle_count_next     = settle_count_reg;
        last_level_next       = last_level_reg;
        pressed_next          = pressed_reg;
        press_time_next       = press_time_reg;
        release_time_next     = release_time_reg;
        release_muted_next    = release_muted_reg | in_data_reg.suppress_release;
        emit                  = 1'b0;
        result.event_kind     = bde_pkg::EV_PRESS;
        result.elapsed_ms     = since_release;

        if (sampled)
        begin
            last_sample_time_next = in_data_reg.now_ms;
            last_level_next       = in_data_reg.pin_level;
            if (!commit)
            begin
                settle_count_next = settle_eff + bde_pkg::COUNT_W'(1);
            end
            else
            begin
                settle_count_next = '0;
                pressed_next      = now_pressed;
                if (rearm_ok)
                begin
                    if (now_pressed && !pressed_reg)
                    begin
                        press_time_next   = in_data_reg.now_ms;
                        emit              = 1'b1;
                        result.event_kind = bde_pkg::EV_PRESS;
                        result.elapsed_ms = since_release;
                    end
                    else if (now_pressed && pressed_reg)
                    begin
                        emit              = 1'b1;
                        result.event_kind = bde_pkg::EV_HOLD;
                        result.elapsed_ms = since_press;
                    end
                    else if (!now_pressed && pressed_reg)
                    begin
                        // a pending mute swallows this release
                        emit               = !release_muted_next;
                        release_muted_next = 1'b0;
                        release_time_next  = in_data_reg.now_ms;
                        result.event_kind  = bde_pkg::EV_RELEASE;
                        result.elapsed_ms  = since_press;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_period_reg   <= bde_pkg::RST_SAMPLE_PERIOD;
            debounce_period_reg <= bde_pkg::RST_DEBOUNCE_PERIOD;
            debounce_count_reg  <= bde_pkg::RST_DEBOUNCE_COUNT;
            rearm_delay_reg     <= bde_pkg::RST_REARM_DELAY;
            active_level_reg    <= bde_pkg::RST_ACTIVE_LEVEL;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                bde_pkg::CFG_SAMPLE_PERIOD:
                    sample_period_reg   <= cfg_data[bde_pkg::SAMPLE_W-1:0];
                bde_pkg::CFG_DEBOUNCE_PERIOD:
                    debounce_period_reg <= cfg_data[bde_pkg::DEBOUNCE_W-1:0];
                bde_pkg::CFG_DEBOUNCE_COUNT:
                    debounce_count_reg  <= cfg_data[bde_pkg::COUNT_W-1:0];
                bde_pkg::CFG_REARM_DELAY:
                    rearm_delay_reg     <= cfg_data[bde_pkg::REARM_W-1:0];
                bde_pkg::CFG_ACTIVE_LEVEL:
                    active_level_reg    <= cfg_data[0];
                default:
                    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg         <= 1'b0;
            out_valid_reg        <= 1'b0;
            last_sample_time_reg <= '0;
            settle_count_reg     <= '0;
            last_level_reg       <= 1'b0;
            pressed_reg          <= 1'b0;
            press_time_reg       <= '0;
            release_time_reg     <= '0;
            release_muted_reg    <= 1'b0;
        end
        else
        begin
            if (!in_stall)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg        <= emit;
                last_sample_time_reg <= last_sample_time_next;
                settle_count_reg     <= settle_count_next;
                last_level_reg       <= last_level_next;
                pressed_reg          <= pressed_next;
                press_time_reg       <= press_time_next;
                release_time_reg     <= release_time_next;
                release_muted_reg    <= release_muted_next;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_data_reg <= in_data;
        end
        if (advance && emit)
        begin
            out_data_reg <= result;
        end
    end

`ifndef SYNTHESIS
    ap_stall_only_behind_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid_reg && out_stall))
        else $error("input stalled with result stage free");

    ap_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_data_reg.event_kind == bde_pkg::EV_PRESS
                        || out_data_reg.event_kind == bde_pkg::EV_HOLD
                        || out_data_reg.event_kind == bde_pkg::EV_RELEASE))
        else $error("illegal event kind");

    ap_press_state: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.event_kind == bde_pkg::EV_PRESS)
        |-> (pressed_reg && press_time_reg == last_sample_time_reg))
        else $error("press beat without press state recorded");

    ap_hold_state: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.event_kind == bde_pkg::EV_HOLD) |-> pressed_reg)
        else $error("hold beat while released");

    ap_release_state: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.event_kind == bde_pkg::EV_RELEASE)
        |-> (!pressed_reg && release_time_reg == last_sample_time_reg
             && !release_muted_reg))
        else $error("release beat without release state recorded");
`endif

endmodule

`default_nettype wire

@@ test/bde_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bde_checker
// Watches the poll, event and register ports of the button event unit, keeps
// its own debounce state and compares every event beat with the prediction.
// ----------------------------------------------------------------------------
module bde_checker
(
    input  wire                                clk,
    input  wire                                rst_n,

    input  wire                                in_valid,
    input  wire                                in_stall,
    input  bde_pkg::in_item_t                  in_data,

    input  wire                                out_valid,
    input  wire                                out_stall,
    input  bde_pkg::out_item_t                 out_data,

    input  wire                                cfg_we,
    input  wire  [bde_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire  [bde_pkg::CFG_DATA_W-1:0]     cfg_data,

    output int unsigned                        pending,
    output int unsigned                        mismatches,
    output int unsigned                        presses,
    output int unsigned                        holds,
    output int unsigned                        releases
);
    import bde_pkg::*;

    // register copies
    logic [SAMPLE_W-1:0]   period_idle;
    logic [DEBOUNCE_W-1:0] period_settle;
    logic [COUNT_W-1:0]    commit_count;
    logic [REARM_W-1:0]    rearm_ms;
    logic                  press_level;

    // debounce state
    logic [TIME_W-1:0]     sampled_at;
    logic [COUNT_W-1:0]    settle_steps;
    logic                  seen_level;
    logic                  is_down;
    logic [TIME_W-1:0]     down_at;
    logic [TIME_W-1:0]     up_at;
    logic                  mute_next_release;

    out_item_t             expected_events[$];
    out_item_t             predicted;
    out_item_t             want;

    // Advances the debounce state by one poll; returns 1 when an event is due.
    function automatic bit debounce_poll(input in_item_t poll, output out_item_t ev);
        logic [TIME_W-1:0] spacing;
        logic              down_before;
        down_before = is_down;
        ev = '0;
        if (poll.suppress_release)
            mute_next_release = 1'b1;
        spacing = (settle_steps == '0) ? TIME_W'(period_idle) : TIME_W'(period_settle);
        if (poll.now_ms - sampled_at < spacing)
            return 1'b0;
        if (poll.pin_level != seen_level)
            settle_steps = COUNT_W'(1);
        sampled_at = poll.now_ms;
        seen_level = poll.pin_level;
        if (settle_steps < commit_count)
        begin
            settle_steps = settle_steps + COUNT_W'(1);
            return 1'b0;
        end
        is_down = (poll.pin_level == press_level);
        settle_steps = '0;
        // still inside the quiet window after the last release
        if (poll.now_ms - up_at < TIME_W'(rearm_ms))
            return 1'b0;
        if (is_down && !down_before)
        begin
            down_at = poll.now_ms;
            ev.event_kind = EV_PRESS;
            ev.elapsed_ms = poll.now_ms - up_at;
            return 1'b1;
        end
        if (is_down)
        begin
            ev.event_kind = EV_HOLD;
            ev.elapsed_ms = poll.now_ms - down_at;
            return 1'b1;
        end
        if (down_before)
        begin
            up_at = poll.now_ms;
            if (mute_next_release)
            begin
                mute_next_release = 1'b0;
                return 1'b0;
            end
            ev.event_kind = EV_RELEASE;
            ev.elapsed_ms = poll.now_ms - down_at;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_idle       = RST_SAMPLE_PERIOD;
            period_settle     = RST_DEBOUNCE_PERIOD;
            commit_count      = RST_DEBOUNCE_COUNT;
            rearm_ms          = RST_REARM_DELAY;
            press_level       = RST_ACTIVE_LEVEL;
            sampled_at        = '0;
            settle_steps      = '0;
            seen_level        = 1'b0;
            is_down           = 1'b0;
            down_at           = '0;
            up_at             = '0;
            mute_next_release = 1'b0;
            expected_events.delete();
            mismatches        = 0;
            presses           = 0;
            holds             = 0;
            releases          = 0;
            pending          <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_SAMPLE_PERIOD:   period_idle   = cfg_data[SAMPLE_W-1:0];
                    CFG_DEBOUNCE_PERIOD: period_settle = cfg_data[DEBOUNCE_W-1:0];
                    CFG_DEBOUNCE_COUNT:  commit_count  = cfg_data[COUNT_W-1:0];
                    CFG_REARM_DELAY:     rearm_ms      = cfg_data[REARM_W-1:0];
                    CFG_ACTIVE_LEVEL:    press_level   = cfg_data[0];
                    default: ;
                endcase
            end

            if (out_valid && !out_stall)
            begin
                if (expected_events.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected event beat: kind %0d elapsed %0d",
                                 $time, out_data.event_kind, out_data.elapsed_ms);
                end
                else
                begin
                    want = expected_events.pop_front();
                    if (out_data.event_kind !== want.event_kind ||
                        out_data.elapsed_ms !== want.elapsed_ms)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display(
                                "%0t: expected kind %0d elapsed %0d, got kind %0d elapsed %0d",
                                $time, want.event_kind, want.elapsed_ms,
                                out_data.event_kind, out_data.elapsed_ms);
                    end
                    else
                    begin
                        case (want.event_kind)
                            EV_PRESS: presses++;
                            EV_HOLD:  holds++;
                            default:  releases++;
                        endcase
                    end
                end
            end

            if (in_valid && !in_stall)
            begin
                if (debounce_poll(in_data, predicted))
                    expected_events.push_back(predicted);
            end

            pending <= expected_events.size();
        end
    end

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives timed pin polls into the button event unit under a series of
// register settings and gap/stall patterns; the checker judges the events.
// ----------------------------------------------------------------------------
module tb;
    import bde_pkg::*;

    localparam int unsigned PHASES        = 8;
    localparam int unsigned POLLS_A_PHASE = 188;
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned QUIET_LIMIT   = 2000;

    logic                    clk       = 1'b0;
    logic                    rst_n     = 1'b0;
    logic                    in_valid  = 1'b0;
    logic                    in_stall;
    in_item_t                in_data   = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    out_item_t               out_data;
    logic                    cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0]  cfg_index = CFG_SAMPLE_PERIOD;
    logic [CFG_DATA_W-1:0]   cfg_data  = '0;

    int unsigned             pending;
    int unsigned             mismatches;
    int unsigned             presses;
    int unsigned             holds;
    int unsigned             releases;

    int unsigned             idle_pct  = 0;
    int unsigned             stall_pct = 0;
    int unsigned             quiet_cycles = 0;
    int unsigned             polls_sent = 0;
    int unsigned             cur_sample = 32'(RST_SAMPLE_PERIOD);
    int unsigned             cur_debounce = 32'(RST_DEBOUNCE_PERIOD);
    logic [TIME_W-1:0]       clock_ms = '0;
    logic                    btn_level = 1'b0;
    int unsigned             bounce_left = 0;

    button_debounce_events_unit u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    bde_checker u_checker
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .pending    (pending),
        .mismatches (mismatches),
        .presses    (presses),
        .holds      (holds),
        .releases   (releases)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
        out_stall <= (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("watchdog: no beat for %0d cycles, %0d events outstanding",
                     QUIET_LIMIT, pending);
            $display("FAILED: results differ");
            $finish;
        end
    end

    task automatic send_poll(input in_item_t poll);
        while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= poll;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        polls_sent++;
    endtask

    task automatic poll_at(input logic [TIME_W-1:0] t, input logic pin, input logic sup);
        in_item_t poll;
        poll.now_ms           = t;
        poll.pin_level        = pin;
        poll.suppress_release = sup;
        send_poll(poll);
    endtask

    // Lets every expected event arrive, then lets the pipeline empty.
    task automatic wait_drained;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apply_settings(input logic [SAMPLE_W-1:0] sp, input logic [DEBOUNCE_W-1:0] dp,
                                  input logic [COUNT_W-1:0] dc, input logic [REARM_W-1:0] rd,
                                  input logic al);
        // junk above each narrower register's width must be ignored
        cfg_we    <= 1'b1;
        cfg_index <= CFG_SAMPLE_PERIOD;
        cfg_data  <= {6'($urandom), sp};
        @(posedge clk);
        cfg_index <= CFG_DEBOUNCE_PERIOD;
        cfg_data  <= {8'($urandom), dp};
        @(posedge clk);
        cfg_index <= CFG_DEBOUNCE_COUNT;
        cfg_data  <= {12'($urandom), dc};
        @(posedge clk);
        cfg_index <= CFG_REARM_DELAY;
        cfg_data  <= rd;
        @(posedge clk);
        cfg_index <= CFG_ACTIVE_LEVEL;
        cfg_data  <= {15'($urandom), al};
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
        cur_sample   = 32'(sp);
        cur_debounce = 32'(dp);
    endtask

    // Mostly a button being pushed and let go, with bounce, on an advancing
    // clock; now and then a poll at an arbitrary time.
    task automatic next_poll(output in_item_t poll);
        int unsigned span;
        span = ((cur_sample > cur_debounce) ? cur_sample : cur_debounce) + 1;
        if ($urandom_range(0, 9) == 0)
        begin
            poll.now_ms    = $urandom;
            poll.pin_level = 1'($urandom_range(0, 1));
            if ($urandom_range(0, 1) == 1)
                clock_ms = poll.now_ms;
        end
        else
        begin
            if ($urandom_range(0, 2) == 0)
                clock_ms = clock_ms + $urandom_range(0, cur_debounce + 1);
            else
                clock_ms = clock_ms + $urandom_range(0, span + span / 2);
            if (bounce_left != 0)
            begin
                bounce_left--;
                poll.pin_level = 1'($urandom_range(0, 1));
            end
            else
            begin
                if ($urandom_range(0, 11) == 0)
                begin
                    btn_level   = ~btn_level;
                    bounce_left = $urandom_range(0, 3);
                end
                poll.pin_level = btn_level;
            end
            poll.now_ms = clock_ms;
        end
        poll.suppress_release = ($urandom_range(0, 15) == 0);
    endtask

    initial
    begin
        in_item_t poll;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: 20 ms idle, 5 ms settle, count 3, 50 ms quiet, active low
        poll_at(32'd0, 1'b1, 1'b0);            // too soon to sample
        poll_at(32'hFFFF_FFFF, 1'b0, 1'b0);    // wrapped gap
        poll_at(32'd19, 1'b0, 1'b0);
        poll_at(32'd39, 1'b0, 1'b0);
        poll_at(32'd59, 1'b0, 1'b0);           // press
        poll_at(32'd79, 1'b0, 1'b0);
        poll_at(32'd99, 1'b0, 1'b0);
        poll_at(32'd119, 1'b0, 1'b0);
        poll_at(32'd139, 1'b0, 1'b0);          // hold from idle resampling
        poll_at(32'd159, 1'b1, 1'b1);          // arm suppression
        poll_at(32'd179, 1'b1, 1'b0);
        poll_at(32'd199, 1'b1, 1'b0);          // muted release
        poll_at(32'd219, 1'b1, 1'b0);
        poll_at(32'd239, 1'b1, 1'b0);
        poll_at(32'd259, 1'b1, 1'b0);
        poll_at(32'd279, 1'b1, 1'b0);          // released level recommitted
        poll_at(32'd299, 1'b0, 1'b0);
        poll_at(32'd319, 1'b0, 1'b0);
        poll_at(32'd339, 1'b0, 1'b0);          // press
        poll_at(32'd359, 1'b1, 1'b0);
        poll_at(32'd379, 1'b1, 1'b0);
        poll_at(32'd399, 1'b1, 1'b0);          // release
        poll_at(32'd419, 1'b0, 1'b0);
        poll_at(32'd424, 1'b0, 1'b0);
        poll_at(32'd429, 1'b0, 1'b0);          // commit inside quiet window
        wait_drained();

        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0: apply_settings(10'd1, 8'd1, 4'd1, 16'd0, 1'b1);
                1: apply_settings(10'd1000, 8'd255, 4'd15, 16'd65535, 1'b0);
                2: apply_settings(10'd0, 8'd0, 4'd0, 16'd0, 1'b1);    // zero periods, zero count and no quiet window
                4: apply_settings(10'($urandom_range(1, 1000)), 8'($urandom_range(1, 255)),
                                  4'($urandom_range(1, 15)), 16'($urandom_range(0, 2000)),
                                  1'($urandom_range(0, 1)));
                default: apply_settings(10'($urandom_range(1, 40)), 8'($urandom_range(1, 10)),
                                        4'($urandom_range(1, 5)), 16'($urandom_range(0, 100)),
                                        1'($urandom_range(0, 1)));
            endcase
            case (phase % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 75; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 75; end
                default: begin idle_pct = 25; stall_pct = 25; end
            endcase
            // odd phases start just short of the wrap
            if (phase % 2 == 1)
                clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 20000);
            for (int i = 0; i < POLLS_A_PHASE; i++)
            begin
                if (phase == 5 && i == POLLS_A_PHASE / 2)
                    wait_drained();
                next_poll(poll);
                send_poll(poll);
            end
            wait_drained();
        end

        idle_pct  = 0;
        stall_pct = 0;
        $display("Sent %0d polls under %0d register settings with sender gaps and event stalls.",
                 polls_sent, PHASES + 1);
        $display("Matched %0d press, %0d hold and %0d release events; %0d mismatches.",
                 presses, holds, releases, mismatches);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
